// File: hw/rtl/lz4bd_pkg.sv
`default_nettype none

package lz4bd_pkg;

   // History window and length counter sizing
   localparam int WINDOW_BYTES = 65536;
   localparam int LENGTH_BITS  = 32;
   localparam int ADDR_BITS    = $clog2(WINDOW_BYTES);
   localparam int COUNT_BITS   = $clog2(WINDOW_BYTES + 1);
   localparam int IDX_BITS     = ADDR_BITS + 2;
   localparam int OFFSET_BITS  = 16;

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

   // Format constants
   localparam logic [7:0] EXT_CONTINUE = 8'hFF;
   localparam logic [3:0] NIBBLE_EXT   = 4'hF;
   localparam logic [3:0] NIBBLE_MASK  = 4'h0F;
   localparam int         MATCH_MIN    = 4;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_OFFSET = 2'd1,
      ST_TRUNCATED  = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      PH_TOKEN    = 7'b0000001,
      PH_LITEXT   = 7'b0000010,
      PH_LITERAL  = 7'b0000100,
      PH_OFFLO    = 7'b0001000,
      PH_OFFHI    = 7'b0010000,
      PH_MATCHEXT = 7'b0100000,
      PH_COPY     = 7'b1000000
   } phase_type;

   // Outcome of one beat, handed from the parser to the output stage
   typedef struct packed {
      logic                 taken;
      logic                 out_valid;
      logic                 out_last;
      status_type           status;
      logic                 from_hist;
      logic [7:0]           lit_byte;
      logic [ADDR_BITS-1:0] wr_addr;
   } step_type;

   // Saturating length add
   function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                      input logic [7:0] b);
      logic [LENGTH_BITS:0] s;
      s = {1'b0, a} + (LENGTH_BITS + 1)'(b);
      return s[LENGTH_BITS] ? LEN_MAX : s[LENGTH_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lz4bd_history.sv
`default_nettype none

module lz4bd_history
   import lz4bd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [7:0]           wr_data,
   output logic      [7:0]           rd_data
);

   logic [7:0] mem [WINDOW_BYTES];
   logic [7:0] q_ff;
   logic [7:0] wdata_ff;
   logic       fwd_ff;
   logic       fwd_in;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q_ff <= mem[rd_addr];
   end

   // Forward the byte written in the same cycle as a read of that entry
   assign fwd_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= fwd_in;
      end
      wdata_ff <= wr_data;
   end

   assign rd_data = fwd_ff ? wdata_ff : q_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lz4bd_parser.sv
`default_nettype none

module lz4bd_parser
   import lz4bd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic                 in_valid,
   input  wire logic [7:0]           in_byte,
   input  wire logic                 in_last,
   output step_type                  result,
   output logic      [ADDR_BITS-1:0] rd_addr
);

   phase_type               phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  lit_rem_ff, lit_rem_in;
   logic [LENGTH_BITS-1:0]  match_rem_ff, match_rem_in;
   logic [3:0]              nibble_ff, nibble_in;
   logic [OFFSET_BITS-1:0]  dist_ff, dist_in;
   logic                    end_after_ff, end_after_in;
   logic [ADDR_BITS-1:0]    wp_ff, wp_in;
   logic [COUNT_BITS-1:0]   produced_ff, produced_in;

   logic [ADDR_BITS-1:0]    wp_adv;
   logic [COUNT_BITS-1:0]   produced_adv;
   logic [IDX_BITS-1:0]     idx_full;
   logic [OFFSET_BITS-1:0]  dist_hi;
   logic                    bad_offset;
   logic [LENGTH_BITS-1:0]  match_base;
   logic [LENGTH_BITS-1:0]  lit_dec;
   logic [LENGTH_BITS-1:0]  match_dec;
   logic [3:0]              lit_nibble;
   logic                    end_blk;

   // Advance write pointer and produced count for one history byte
   assign wp_adv = (wp_ff == ADDR_BITS'(WINDOW_BYTES - 1)) ? '0 : wp_ff + 1'b1;
   assign produced_adv = (produced_ff < COUNT_BITS'(WINDOW_BYTES)) ?
                         produced_ff + 1'b1 : produced_ff;

   // Copy source: write pointer minus distance, modulo the window
   assign idx_full = IDX_BITS'(wp_ff)
                   + ((IDX_BITS'(wp_ff) >= IDX_BITS'(dist_ff)) ? '0 : IDX_BITS'(WINDOW_BYTES))
                   - IDX_BITS'(dist_ff);
   assign rd_addr = idx_full[ADDR_BITS-1:0];

   // Offset checks use the distance after this beat's high byte
   assign dist_hi = {in_byte, dist_ff[7:0]};
   assign match_base = LENGTH_BITS'(nibble_ff) + LENGTH_BITS'(MATCH_MIN);
   assign lit_dec = (lit_rem_ff != '0) ? lit_rem_ff - 1'b1 : lit_rem_ff;
   assign match_dec = match_rem_ff - 1'b1;
   assign lit_nibble = in_byte[7:4];

   // Next state and beat outcome
   always_comb begin
      phase_in     = phase_ff;
      lit_rem_in   = lit_rem_ff;
      match_rem_in = match_rem_ff;
      nibble_in    = nibble_ff;
      dist_in      = dist_ff;
      end_after_in = end_after_ff;
      wp_in        = wp_ff;
      produced_in  = produced_ff;
      end_blk      = 1'b0;
      bad_offset   = 1'b0;
      result           = '0;
      result.status    = ST_OK;
      result.wr_addr   = wp_ff;
      result.lit_byte  = in_byte;

      if (phase_ff == PH_COPY) begin
         if (match_rem_ff == '0) begin
            phase_in = PH_TOKEN;
         end else begin
            result.out_valid = 1'b1;
            result.from_hist = 1'b1;
            wp_in        = wp_adv;
            produced_in  = produced_adv;
            match_rem_in = match_dec;
            if (match_dec == '0) begin
               if (end_after_ff) begin
                  result.out_last = 1'b1;
                  end_blk = 1'b1;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
         end
      end else if (in_valid) begin
         result.taken = 1'b1;
         case (phase_ff)
            PH_LITEXT: begin
               lit_rem_in = sat_add(lit_rem_ff, in_byte);
               if (in_byte != EXT_CONTINUE) begin
                  phase_in = PH_LITERAL;
               end
               if (in_last) begin
                  result.status = ST_TRUNCATED;
                  end_blk = 1'b1;
               end
            end
            PH_LITERAL: begin
               result.out_valid = 1'b1;
               wp_in       = wp_adv;
               produced_in = produced_adv;
               lit_rem_in  = lit_dec;
               if (lit_dec == '0) begin
                  phase_in = PH_OFFLO;
                  if (in_last) begin
                     result.out_last = 1'b1;
                     end_blk = 1'b1;
                  end
               end else if (in_last) begin
                  result.out_last = 1'b1;
                  result.status   = ST_TRUNCATED;
                  end_blk = 1'b1;
               end
            end
            PH_OFFLO: begin
               dist_in  = OFFSET_BITS'(in_byte);
               phase_in = PH_OFFHI;
               if (in_last) begin
                  result.status = ST_TRUNCATED;
                  end_blk = 1'b1;
               end
            end
            PH_OFFHI: begin
               dist_in      = dist_hi;
               match_rem_in = match_base;
               if (nibble_ff == NIBBLE_EXT) begin
                  phase_in = PH_MATCHEXT;
                  if (in_last) begin
                     result.status = ST_TRUNCATED;
                     end_blk = 1'b1;
                  end
               end else begin
                  bad_offset = (dist_hi == '0) ||
                               (32'(dist_hi) > 32'(produced_ff));
                  if (bad_offset) begin
                     result.status = ST_BAD_OFFSET;
                     match_rem_in  = '0;
                     phase_in      = PH_TOKEN;
                     end_blk       = in_last;
                  end else begin
                     phase_in     = PH_COPY;
                     end_after_in = in_last;
                  end
               end
            end
            PH_MATCHEXT: begin
               match_rem_in = sat_add(match_rem_ff, in_byte);
               if (in_byte == EXT_CONTINUE) begin
                  if (in_last) begin
                     result.status = ST_TRUNCATED;
                     end_blk = 1'b1;
                  end
               end else begin
                  bad_offset = (dist_ff == '0) ||
                               (32'(dist_ff) > 32'(produced_ff));
                  if (bad_offset) begin
                     result.status = ST_BAD_OFFSET;
                     match_rem_in  = '0;
                     phase_in      = PH_TOKEN;
                     end_blk       = in_last;
                  end else begin
                     phase_in     = PH_COPY;
                     end_after_in = in_last;
                  end
               end
            end
            default: begin
               // Token: high nibble literal count, low nibble match count minus four
               nibble_in  = in_byte[3:0] & NIBBLE_MASK;
               lit_rem_in = LENGTH_BITS'(lit_nibble);
               if (lit_nibble == NIBBLE_EXT) begin
                  phase_in = PH_LITEXT;
               end else if (lit_nibble != 4'd0) begin
                  phase_in = PH_LITERAL;
               end else begin
                  phase_in = PH_OFFLO;
               end
               if (in_last) begin
                  if (lit_nibble != 4'd0) begin
                     result.status = ST_TRUNCATED;
                  end
                  end_blk = 1'b1;
               end
            end
         endcase
      end

      // Drop all sequence state at block end; history contents stay
      if (end_blk) begin
         phase_in     = PH_TOKEN;
         lit_rem_in   = '0;
         match_rem_in = '0;
         nibble_in    = '0;
         dist_in      = '0;
         end_after_in = 1'b0;
         wp_in        = '0;
         produced_in  = '0;
      end
   end

   // Hold state between beats
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TOKEN;
         lit_rem_ff   <= '0;
         match_rem_ff <= '0;
         nibble_ff    <= '0;
         dist_ff      <= '0;
         end_after_ff <= 1'b0;
         wp_ff        <= '0;
         produced_ff  <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         lit_rem_ff   <= lit_rem_in;
         match_rem_ff <= match_rem_in;
         nibble_ff    <= nibble_in;
         dist_ff      <= dist_in;
         end_after_ff <= end_after_in;
         wp_ff        <= wp_in;
         produced_ff  <= produced_in;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/lz4_block_decoder.sv
`default_nettype none

// LZ4 block decoder. Each request beat is one decoder tick: it offers (or does not
// offer) one compressed byte, and exactly one response beat comes back telling
// whether that byte was consumed, the decompressed byte emitted on that tick (a
// literal or one byte of a match copy), a last-byte mark and a status (ok, bad
// match offset, block ended mid-sequence). While a match copy runs, offered bytes
// are reported as not taken and must be offered again. A new beat is accepted on
// every cycle in which the response register is empty or being drained, so the
// sustained rate is one tick per cycle, and each response is registered. Match
// bytes come from a 64 KiB single-port-write history RAM with a registered read;
// a copy whose source is the byte written in the previous tick is served by
// forwarding, so distance-one runs keep full rate. History RAM contents are not
// cleared by reset or at block end; the offset check keeps reads inside bytes
// already produced in the current block.
module lz4_block_decoder
   import lz4bd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       req_in_valid,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_taken,
   output logic            rsp_out_valid,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last,
   output logic [1:0]      rsp_status
);

   logic                 accept;
   step_type             step_res;
   logic [ADDR_BITS-1:0] rd_addr;
   logic [7:0]           hist_byte;
   logic [7:0]           byte_now;
   logic                 wr_en;

   step_type             stage_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 fresh_ff;
   logic [7:0]           out_byte_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   lz4bd_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .step     (accept),
      .in_valid (req_in_valid),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .result   (step_res),
      .rd_addr  (rd_addr)
   );

   // Resolve the emitted byte on the cycle after the beat, when read data lands
   always_comb begin
      if (!stage_ff.out_valid) begin
         byte_now = 8'd0;
      end else if (stage_ff.from_hist) begin
         byte_now = hist_byte;
      end else begin
         byte_now = stage_ff.lit_byte;
      end
   end

   // Write each emitted byte into history in the cycle after its beat
   assign wr_en = fresh_ff && stage_ff.out_valid;

   lz4bd_history u_history (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (stage_ff.wr_addr),
      .wr_data (byte_now),
      .rd_data (hist_byte)
   );

   // Response register: load on accept, drop when drained
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         fresh_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         fresh_ff     <= accept;
      end
      if (accept) begin
         stage_ff <= step_res;
      end
      if (fresh_ff) begin
         out_byte_ff <= byte_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_taken     = stage_ff.taken;
   assign rsp_out_valid = stage_ff.out_valid;
   assign rsp_out_byte  = fresh_ff ? byte_now : out_byte_ff;
   assign rsp_out_last  = stage_ff.out_last;
   assign rsp_status    = stage_ff.status;

endmodule

`default_nettype wire

// File: tb/tb_lz4_block_decoder.sv
`default_nettype none

module tb_lz4_block_decoder
   import lz4bd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_BEATS = 750;
   localparam int unsigned HOLD_AT      = 150;
   localparam int unsigned PAUSE_AT     = 350;
   localparam int unsigned STEADY_FROM  = 450;
   localparam int unsigned STEADY_UNTIL = 600;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned SETTLE       = 20;

   // What one decoder tick reports back
   typedef struct packed {
      logic       taken;
      logic       emit;
      logic [7:0] data;
      logic       last;
      status_type st;
   } tick_out_t;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } comp_byte_t;

   typedef struct {
      bit        iv;
      bit [7:0]  data;
      bit        last;
      bit        typed;
      tick_out_t want;
   } script_row_t;

   localparam tick_out_t QUIET      = '{1'b0, 1'b0, 8'h00, 1'b0, ST_OK};
   localparam tick_out_t TAKEN_ONLY = '{1'b1, 1'b0, 8'h00, 1'b0, ST_OK};
   localparam tick_out_t BAD_OFF    = '{1'b1, 1'b0, 8'h00, 1'b0, ST_BAD_OFFSET};
   localparam tick_out_t CUT_SHORT  = '{1'b1, 1'b0, 8'h00, 1'b0, ST_TRUNCATED};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_in_valid = 1'b0;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_taken;
   logic       rsp_out_valid;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_last;
   logic [1:0] rsp_status;

   // Decoder state mirrored for prediction
   phase_type              dec_phase = PH_TOKEN;
   bit [LENGTH_BITS-1:0]   lit_left;
   bit [LENGTH_BITS-1:0]   copy_left;
   bit [3:0]               copy_nibble;
   bit [15:0]              copy_dist;
   bit                     end_on_copy;
   bit [7:0]               hist_mem [WINDOW_BYTES];
   bit [15:0]              wr_ptr;
   bit [16:0]              produced;

   tick_out_t   due_ticks[$];
   comp_byte_t  comp_stream[$];
   comp_byte_t  staged[$];
   int unsigned mismatches;
   int unsigned rsp_count;
   int unsigned cycles;
   bit          steady;
   bit          rsp_hold_req;

   // Opening rows: fresh block edges, every parse phase, both error codes
   script_row_t opening_rows [28] = '{
      '{1'b0, 8'hFF, 1'b1, 1'b1, QUIET},       // idle tick
      '{1'b1, 8'h00, 1'b1, 1'b1, TAKEN_ONLY},  // empty block
      '{1'b1, 8'h30, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'hFF, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'hA5, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b0, 1'b1, BAD_OFF},     // zero offset
      '{1'b1, 8'h01, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h03, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b0, 1'b0, QUIET},
      '{1'b0, 8'h3C, 1'b1, 1'b0, QUIET},       // idle tick during copy
      '{1'b1, 8'h1F, 1'b0, 1'b0, QUIET},       // held back until copy ends
      '{1'b1, 8'h5A, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h01, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'hFF, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h02, 1'b1, 1'b0, QUIET},       // long distance-one run ends block
      '{1'b1, 8'hF0, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b1, 1'b1, CUT_SHORT},   // cut in literal length
      '{1'b1, 8'h20, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h11, 1'b1, 1'b1, '{1'b1, 1'b1, 8'h11, 1'b1, ST_TRUNCATED}},
      '{1'b1, 8'h00, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'hFF, 1'b1, 1'b1, CUT_SHORT},   // cut in offset
      '{1'b1, 8'h10, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h77, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h02, 1'b0, 1'b0, QUIET},
      '{1'b1, 8'h00, 1'b1, 1'b1, BAD_OFF}      // offset past output, block ends
   };

   lz4_block_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_valid  (req_in_valid),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_taken     (rsp_taken),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_status    (rsp_status)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit [LENGTH_BITS-1:0] grow_len(input bit [LENGTH_BITS-1:0] n,
                                                     input bit [7:0] add);
      return (n > LEN_MAX - add) ? LEN_MAX : n + add;
   endfunction

   function automatic void close_block();
      dec_phase   = PH_TOKEN;
      lit_left    = '0;
      copy_left   = '0;
      copy_nibble = '0;
      copy_dist   = '0;
      end_on_copy = 1'b0;
      wr_ptr      = '0;
      produced    = '0;
   endfunction

   function automatic void store_byte(input bit [7:0] b);
      hist_mem[wr_ptr] = b;
      wr_ptr++;
      if (produced < WINDOW_BYTES) produced++;
   endfunction

   // Start a copy, or drop it when the offset reaches outside this block's output
   function automatic bit begin_copy(input bit lst);
      if (copy_dist == 0 || copy_dist > produced) begin
         copy_left = '0;
         if (lst) close_block();
         else dec_phase = PH_TOKEN;
         return 1'b1;
      end
      dec_phase   = PH_COPY;
      end_on_copy = lst;
      return 1'b0;
   endfunction

   task automatic decode_tick(input bit iv, input bit [7:0] b, input bit lst,
                              output tick_out_t r);
      bit [3:0]  lit_nib;
      bit [15:0] src;
      r.taken = 1'b0;
      r.emit  = 1'b0;
      r.data  = 8'h00;
      r.last  = 1'b0;
      r.st    = ST_OK;
      if (dec_phase == PH_COPY) begin
         // emit one match byte; the offered byte waits
         if (copy_left == 0) begin
            dec_phase = PH_TOKEN;
         end else begin
            src    = wr_ptr - copy_dist;
            r.emit = 1'b1;
            r.data = hist_mem[src];
            store_byte(hist_mem[src]);
            copy_left--;
            if (copy_left == 0) begin
               if (end_on_copy) begin
                  r.last = 1'b1;
                  close_block();
               end else begin
                  dec_phase = PH_TOKEN;
               end
            end
         end
      end else if (iv) begin
         r.taken = 1'b1;
         case (dec_phase)
            PH_LITEXT: begin
               lit_left = grow_len(lit_left, b);
               if (b != EXT_CONTINUE) dec_phase = PH_LITERAL;
               if (lst) begin
                  r.st = ST_TRUNCATED;
                  close_block();
               end
            end
            PH_LITERAL: begin
               r.emit = 1'b1;
               r.data = b;
               store_byte(b);
               if (lit_left != 0) lit_left--;
               if (lit_left == 0) begin
                  dec_phase = PH_OFFLO;
                  if (lst) begin
                     r.last = 1'b1;
                     close_block();
                  end
               end else if (lst) begin
                  r.last = 1'b1;
                  r.st   = ST_TRUNCATED;
                  close_block();
               end
            end
            PH_OFFLO: begin
               copy_dist = {8'h00, b};
               dec_phase = PH_OFFHI;
               if (lst) begin
                  r.st = ST_TRUNCATED;
                  close_block();
               end
            end
            PH_OFFHI: begin
               copy_dist[15:8] = b;
               copy_left       = copy_nibble + MATCH_MIN;
               if (copy_nibble == NIBBLE_EXT) begin
                  dec_phase = PH_MATCHEXT;
                  if (lst) begin
                     r.st = ST_TRUNCATED;
                     close_block();
                  end
               end else if (begin_copy(lst)) begin
                  r.st = ST_BAD_OFFSET;
               end
            end
            PH_MATCHEXT: begin
               copy_left = grow_len(copy_left, b);
               if (b == EXT_CONTINUE) begin
                  if (lst) begin
                     r.st = ST_TRUNCATED;
                     close_block();
                  end
               end else if (begin_copy(lst)) begin
                  r.st = ST_BAD_OFFSET;
               end
            end
            default: begin
               // token: literal count high, match count low
               lit_nib     = b[7:4];
               copy_nibble = b[3:0];
               lit_left    = lit_nib;
               if (lit_nib == NIBBLE_EXT) dec_phase = PH_LITEXT;
               else if (lit_nib != 0) dec_phase = PH_LITERAL;
               else dec_phase = PH_OFFLO;
               if (lst) begin
                  if (lit_nib != 0) r.st = ST_TRUNCATED;
                  close_block();
               end
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------- stream building

   function automatic void put_byte(input bit [7:0] b);
      staged.push_back('{data: b, last: 1'b0});
   endfunction

   function automatic void put_ext(input int unsigned rem);
      while (rem >= 255) begin
         put_byte(EXT_CONTINUE);
         rem -= 255;
      end
      put_byte(8'(rem));
   endfunction

   function automatic void put_token(input int unsigned lit, input int unsigned mext);
      bit [3:0] hi;
      bit [3:0] lo;
      hi = (lit >= 15) ? NIBBLE_EXT : 4'(lit);
      lo = (mext >= 15) ? NIBBLE_EXT : 4'(mext);
      put_byte({hi, lo});
      if (lit >= 15) put_ext(lit - 15);
   endfunction

   function automatic int unsigned pick_lit_len();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 65) return $urandom_range(4);
      if (roll < 92) return $urandom_range(20, 5);
      if (roll < 99) return $urandom_range(40, 21);
      return $urandom_range(290, 270);
   endfunction

   function automatic int unsigned pick_match_len();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(10, 4);
      if (roll < 94) return $urandom_range(40, 11);
      return $urandom_range(300, 274);
   endfunction

   // Append one compressed block: mostly well formed, some cut short, some noise
   task automatic build_block();
      int unsigned kind;
      int unsigned lit;
      int unsigned mlen;
      int unsigned made;
      int unsigned offs;
      int unsigned lim;
      int unsigned cut;
      staged.delete();
      kind = $urandom_range(99);
      if (kind < 12) begin
         repeat ($urandom_range(12, 1))
            staged.push_back('{data: 8'($urandom), last: ($urandom_range(7) == 0)});
      end else begin
         made = 0;
         repeat ($urandom_range(4, 1)) begin
            lit  = pick_lit_len();
            mlen = pick_match_len();
            put_token(lit, mlen - MATCH_MIN);
            repeat (lit) put_byte(8'($urandom));
            made += lit;
            if (made != 0 && $urandom_range(15) != 0) begin
               lim  = (made > 65535) ? 65535 : made;
               offs = $urandom_range(1) ? $urandom_range((lim > 8) ? 8 : lim, 1)
                                        : $urandom_range(lim, 1);
               made += mlen;
            end else if (made < 65535 && $urandom_range(1)) begin
               offs = $urandom_range(65535, made + 1);
            end else begin
               offs = 0;
            end
            put_byte(offs[7:0]);
            put_byte(offs[15:8]);
            if (mlen - MATCH_MIN >= 15) put_ext(mlen - MATCH_MIN - 15);
         end
         // close with trailing literals, an empty token, or on the last match's offset or length bytes
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
               lit = pick_lit_len();
               put_token(lit, $urandom_range(15));
               repeat (lit) put_byte(8'($urandom));
            end
            6, 7: put_token(0, $urandom_range(15));
            default: ;
         endcase
         if (kind < 26) begin
            cut = $urandom_range(staged.size() - 1);
            while (staged.size() > cut + 1) void'(staged.pop_back());
         end
      end
      staged[staged.size() - 1].last = 1'b1;
      comp_stream = {comp_stream, staged};
   endtask

   // ---------------------------------------------------------------- driving

   task automatic sender_gap();
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic offer_tick(input bit iv, input bit [7:0] b, input bit lst,
                             output tick_out_t r);
      req_valid    <= 1'b1;
      req_in_valid <= iv;
      req_in_byte  <= b;
      req_in_last  <= lst;
      do @(posedge clock); while (!req_ready);
      decode_tick(iv, b, lst, r);
   endtask

   task automatic drain_ticks();
      req_valid <= 1'b0;
      do @(posedge clock); while (due_ticks.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] response %0d: %s is %0d, expected %0d",
               $realtime, rsp_count, what, got, want);
      mismatches++;
   endtask

   // Receiver: random backpressure, plus one long hold on request
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(99) >= 30);
         end
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      tick_out_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_ticks.size() == 0) begin
            report_mismatch("unrequested beat", 1, 0);
         end else begin
            want = due_ticks.pop_front();
            if (rsp_taken !== want.taken) report_mismatch("taken", rsp_taken, want.taken);
            if (rsp_out_valid !== want.emit)
               report_mismatch("out_valid", rsp_out_valid, want.emit);
            if (rsp_out_byte !== want.data)
               report_mismatch("out_byte", rsp_out_byte, want.data);
            if (rsp_out_last !== want.last)
               report_mismatch("out_last", rsp_out_last, want.last);
            if (rsp_status !== want.st) report_mismatch("status", rsp_status, want.st);
         end
         rsp_count++;
      end
   end

   // Give up on a hung run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      tick_out_t   got;
      int unsigned beats_sent;
      bit          held;
      bit          paused;
      beats_sent = 0;
      held       = 1'b0;
      paused     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the opening rows; a byte refused during a copy is offered again
      foreach (opening_rows[i]) begin
         do begin
            sender_gap();
            offer_tick(opening_rows[i].iv, opening_rows[i].data, opening_rows[i].last, got);
            due_ticks.push_back(opening_rows[i].typed ? opening_rows[i].want : got);
         end while (opening_rows[i].iv && !got.taken);
      end

      // Random blocks, one request beat per pass
      while (beats_sent < RANDOM_BEATS) begin
         if (comp_stream.size() == 0) build_block();
         if (beats_sent >= HOLD_AT && !held) begin
            held         = 1'b1;
            rsp_hold_req = 1'b1;
         end
         if (beats_sent >= PAUSE_AT && !paused) begin
            paused = 1'b1;
            drain_ticks();
         end
         steady = (beats_sent >= STEADY_FROM && beats_sent < STEADY_UNTIL);
         sender_gap();
         if ($urandom_range(99) < 8) begin
            offer_tick(1'b0, 8'($urandom), 1'($urandom), got);
         end else begin
            offer_tick(1'b1, comp_stream[0].data, comp_stream[0].last, got);
            if (got.taken) begin
               void'(comp_stream.pop_front());
            end
         end
         due_ticks.push_back(got);
         beats_sent++;
      end

      drain_ticks();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
